>>> hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// shared widths, codes and defaults of the linear-probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int OP_W        = 2;
	localparam int KEY_W       = 31;
	localparam int IN_VALUE_W  = 32;
	localparam int STATUS_W    = 2;
	localparam int OUT_VALUE_W = 32;
	localparam int CFG_W       = 8;
	localparam int SLOT_ST_W   = 2;

	localparam int S_TDATA_W   = 72;
	localparam int M_TDATA_W   = 40;

	localparam int DEPTH_DEFAULT   = 128;
	localparam int VALUE_W_DEFAULT = 32;

	localparam logic [CFG_W-1:0] SIZE_RESET = 8'd101;

	localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [SLOT_ST_W-1:0] ST_EMPTY   = 2'd0;
	localparam logic [SLOT_ST_W-1:0] ST_ACTIVE  = 2'd1;
	localparam logic [SLOT_ST_W-1:0] ST_DELETED = 2'd2;

	localparam logic [STATUS_W-1:0] RES_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] RES_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] RES_FULL    = 2'd2;

endpackage

>>> hdl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// closed hash table with linear probing, one operation per input word
// ----------------------------------------------------------------------------
// s_* carries one operation word: find, insert or remove of a key (and value
// on insert). m_* returns one result word per operation: status and, for a
// successful find, the stored value. cfg_we/cfg_wdata write the table size;
// the user must write it only while the block is idle; the block does not check.
// An operation is accepted in the idle state, then runs through the remainder
// unit (key modulo size, one key bit a cycle, then the done flag), reads and
// checks each probed slot through the slot memory, and loads its result; an
// invalid op code goes straight to the result with status missing. One
// operation is in flight at a time; s_tready is high only when the sequencer
// is idle.
// After reset the slot states are swept to empty, one slot a cycle, through
// all TABLE_DEPTH slots; s_tready stays low meanwhile, cfg writes are taken.
// The result sits in an output register; while the receiver stalls the
// next operation can be accepted and worked on, and it waits for the
// register to empty before its own result is loaded.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
	import lpht_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int VALUE_WIDTH = VALUE_W_DEFAULT
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // op, key, value, zero pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // status, found_value, zero pad
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = SLOT_ST_W + KEY_W + VALUE_WIDTH;
	localparam int VEXT_W  = VALUE_WIDTH + IN_VALUE_W + OUT_VALUE_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]             state_q;
	logic [CFG_W-1:0]       table_size_q;
	logic [CFG_W-1:0]       size_use;
	logic                   accept;
	logic                   op_valid;

	logic [OP_W-1:0]        op_q;
	logic [KEY_W-1:0]       key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [CFG_W-1:0]       size_q;
	logic [CFG_W-1:0]       pos_q;
	logic [CFG_W-1:0]       n_q;
	logic [STATUS_W-1:0]    status_q;
	logic [VALUE_WIDTH-1:0] fv_q;

	logic                   m_tvalid_q;
	logic [STATUS_W-1:0]    m_status_q;
	logic [OUT_VALUE_W-1:0] m_value_q;

	logic                   mod_done;
	logic [CFG_W-1:0]       mod_rem;
	logic                   clr_busy;

	logic [IDX_W-1:0]       rd_addr;
	logic [ENTRY_W-1:0]     rd_data;
	logic                   wr_en;
	logic [ENTRY_W-1:0]     wr_data;

	logic [SLOT_ST_W-1:0]   rd_st;
	logic [KEY_W-1:0]       rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic                   hit;
	logic                   last;
	logic [CFG_W-1:0]       pos_next;
	logic [IDX_W+CFG_W-1:0] addr_ext;
	logic [VEXT_W-1:0]      in_vext;
	logic [VEXT_W-1:0]      out_vext;
	logic                   out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && !clr_busy;
	assign op_valid = (s_tdata[OP_W-1:0] == OP_FIND) || (s_tdata[OP_W-1:0] == OP_INSERT)
		|| (s_tdata[OP_W-1:0] == OP_REMOVE);
	assign out_free = !m_tvalid_q || m_tready;

	// 0 acts as 1, anything above the depth acts as the depth
	always_comb begin
		if (table_size_q == '0)
			size_use = CFG_W'(1);
		else if (32'(table_size_q) > TABLE_DEPTH)
			size_use = CFG_W'(TABLE_DEPTH);
		else
			size_use = table_size_q;
	end

	always_comb begin
		in_vext  = VEXT_W'(s_tdata[OP_W+KEY_W +: IN_VALUE_W]);
		out_vext = VEXT_W'(fv_q);
		addr_ext = (IDX_W+CFG_W)'(pos_q);
		rd_addr  = addr_ext[IDX_W-1:0];
		rd_st    = rd_data[ENTRY_W-1 -: SLOT_ST_W];
		rd_key   = rd_data[VALUE_WIDTH +: KEY_W];
		rd_val   = rd_data[VALUE_WIDTH-1:0];
		hit      = (rd_st == ST_ACTIVE) && (rd_key == key_q);
		last     = ({1'b0, n_q} + 1'b1) == {1'b0, size_q};
		pos_next = (({1'b0, pos_q} + 1'b1) == {1'b0, size_q}) ? '0 : pos_q + 1'b1;
	end

	// slot write on a free insert slot or a remove hit
	always_comb begin
		wr_en   = 1'b0;
		wr_data = {ST_ACTIVE, key_q, value_q};
		if (state_q == S_CHECK) begin
			if (op_q == OP_INSERT) begin
				wr_en = (rd_st != ST_ACTIVE);
			end else if (op_q == OP_REMOVE) begin
				wr_en   = hit;
				wr_data = {ST_DELETED, rd_key, rd_val};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			table_size_q <= SIZE_RESET;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				table_size_q <= cfg_wdata;
			if (state_q == S_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= op_valid ? S_HASH : S_DONE;
				end
				S_HASH: begin
					if (mod_done)
						state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (op_q == OP_INSERT) begin
						if (rd_st != ST_ACTIVE || last)
							state_q <= S_DONE;
						else
							state_q <= S_READ;
					end else if (rd_st == ST_EMPTY || hit || last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= s_tdata[OP_W-1:0];
			key_q    <= s_tdata[OP_W +: KEY_W];
			value_q  <= in_vext[VALUE_WIDTH-1:0];
			size_q   <= size_use;
			status_q <= RES_MISSING;
			fv_q     <= '0;
		end
		if (state_q == S_HASH && mod_done) begin
			pos_q <= mod_rem;
			n_q   <= '0;
		end
		if (state_q == S_CHECK) begin
			pos_q <= pos_next;
			n_q   <= n_q + 1'b1;
			if (op_q == OP_INSERT) begin
				if (rd_st != ST_ACTIVE)
					status_q <= RES_OK;
				else if (last)
					status_q <= RES_FULL;
			end else if (hit) begin
				status_q <= RES_OK;
				if (op_q == OP_FIND)
					fv_q <= rd_val;
			end
		end
		if (state_q == S_DONE && out_free) begin
			m_status_q <= status_q;
			m_value_q  <= out_vext[OUT_VALUE_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-STATUS_W-OUT_VALUE_W){1'b0}}, m_value_q, m_status_q};

	lpht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && op_valid),
		.key    (s_tdata[OP_W +: KEY_W]),
		.size   (size_use),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	lpht_slots #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (rd_addr),
		.wr_data  (wr_data),
		.clr_busy (clr_busy)
	);

endmodule

>>> hdl/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// iterative remainder of the key by the table size, one key bit a cycle
// ----------------------------------------------------------------------------
module lpht_mod
	import lpht_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	input  logic [CFG_W-1:0] size,
	output logic             done,
	output logic [CFG_W-1:0] rem
);

	localparam int CNT_W = $clog2(KEY_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] dividend_q;
	logic [CFG_W-1:0] size_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   diff;
	logic [CFG_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, dividend_q[KEY_W-1]};
		diff     = trial - {1'b0, size_q};
		rem_next = (trial >= {1'b0, size_q}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(KEY_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(KEY_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= key;
			size_q     <= size;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[KEY_W-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> hdl/lpht_slots.sv
// ----------------------------------------------------------------------------
// lpht_slots
// slot memory (state, key, value) with registered read and clearing pass
// ----------------------------------------------------------------------------
module lpht_slots
	import lpht_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int VALUE_WIDTH = VALUE_W_DEFAULT,
	localparam int IDX_W      = $clog2(TABLE_DEPTH),
	localparam int ENTRY_W    = SLOT_ST_W + KEY_W + VALUE_WIDTH
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic               clr_busy
);

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic               clr_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic               we;
	logic [IDX_W-1:0]   wa;
	logic [ENTRY_W-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	// clearing pass owns the write port
	always_comb begin
		if (clr_q) begin
			we = 1'b1;
			wa = clr_idx_q;
			wd = {ST_EMPTY, {(ENTRY_W-SLOT_ST_W){1'b0}}};
		end else begin
			we = wr_en;
			wa = wr_addr;
			wd = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[rd_addr];
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_q;

endmodule
